@@ hdl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and codes of the set-associative LRU cache tag unit.
// ----------------------------------------------------------------------------
package sacl_pkg;

  typedef enum logic [2:0] {
    KIND_READ     = 3'd0,
    KIND_WRITE    = 3'd1,
    KIND_PREFETCH = 3'd2,
    KIND_PROBE    = 3'd3,
    KIND_INVAL    = 3'd4
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  localparam logic [2:0] REG_WRITE_THROUGH = 3'd0;
  localparam logic [2:0] REG_INSERT_AT_LRU = 3'd4;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ hdl/sacl_ram.sv @@
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sacl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: captures an item, then runs the set update once the result
// register is free.
// ----------------------------------------------------------------------------
module sacl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sacl_pkg::ctrl_sts_t  sts_i,
  output sacl_pkg::ctrl_cmd_t  cmd_o
);

  sacl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sacl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sacl_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sacl_pkg::ST_EXEC;
      end
      sacl_pkg::ST_EXEC: begin
        if (sts_i.out_free) state_d = sacl_pkg::ST_IDLE;
      end
      default: state_d = sacl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      sacl_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      sacl_pkg::ST_EXEC: begin
        cmd_o.execute = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

@@ hdl/sacl_dp.sv @@
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath: set row RAM, valid bits, way compare, LRU update and result
// register.
// ----------------------------------------------------------------------------
module sacl_dp #(
  parameter int OFFSET_BITS = 6,
  parameter int INDEX_BITS  = 6,
  parameter int WAYS_LOG2   = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sacl_pkg::ctrl_cmd_t cmd_i,
  output sacl_pkg::ctrl_sts_t sts_o,
  input  logic                write_through_i,
  input  logic                insert_at_lru_i,
  input  logic [2:0]          kind_i,
  input  logic [63:0]         addr_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic                fetch_valid_o,
  output logic [63:0]         fetch_addr_o,
  output logic                writeback_valid_o,
  output logic [63:0]         writeback_addr_o,
  output logic                prefetch_used_o,
  output logic                prefetch_wasted_o,
  output logic                filled_o
);

  localparam int TW   = 64 - OFFSET_BITS - INDEX_BITS;
  localparam int SETS = 1 << INDEX_BITS;
  localparam int WAYS = 1 << WAYS_LOG2;
  localparam int RW   = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;
  localparam int CW   = WAYS_LOG2 + 1;
  localparam int LW   = TW + 2 + RW;

  logic [2:0]              kind_q;
  logic [63:0]             addr_q;
  logic [INDEX_BITS-1:0]   set_idx;
  logic [TW-1:0]           tag_in;
  logic [WAYS*LW-1:0]      row_rd, row_wr;
  logic [WAYS-1:0]         valid_q [SETS];
  logic [WAYS-1:0]         vrow, nv;
  logic [TW-1:0]           tg [WAYS];
  logic [TW-1:0]           ntg [WAYS];
  logic [RW-1:0]           rk [WAYS];
  logic [RW-1:0]           nrk [WAYS];
  logic [WAYS-1:0]         dt, pf, ndt, npf;
  logic                    wt;

  logic                    hit, fv, wv, pu, pw, fl;
  logic                    out_valid_q;
  logic                    hit_q, fv_q, wv_q, pu_q, pw_q, fl_q;
  logic [63:0]             fa_q, wa_q;
  logic [63:0]             wa;

  assign set_idx = addr_q[OFFSET_BITS +: INDEX_BITS];
  assign tag_in  = addr_q[63 -: TW];
  assign wt      = write_through_i;
  assign vrow    = valid_q[set_idx];

  sacl_ram #(
    .WIDTH (WAYS * LW),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.execute),
    .waddr_i (set_idx),
    .wdata_i (row_wr),
    .re_i    (cmd_i.capture),
    .raddr_i (addr_i[OFFSET_BITS +: INDEX_BITS]),
    .rdata_o (row_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      addr_q <= addr_i;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tg[w] = row_rd[w*LW + 2 + RW +: TW];
      dt[w] = row_rd[w*LW + 1 + RW] & vrow[w];
      pf[w] = row_rd[w*LW + RW] & vrow[w];
      rk[w] = vrow[w] ? row_rd[w*LW +: RW] : '0;
    end
  end

  always_comb begin
    logic          hfound, vfound, is_demand, is_wr, do_ins, ins_dt, ins_pf, evict;
    logic          do_rem;
    logic [RW-1:0] hway, vway, rway, slot, best, r;
    logic [CW-1:0] cnt;
    nv   = vrow;
    ndt  = dt;
    npf  = pf;
    r    = '0;
    slot = '0;
    for (int w = 0; w < WAYS; w++) begin
      ntg[w] = tg[w];
      nrk[w] = rk[w];
    end
    hfound = 1'b0;
    hway   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hfound && vrow[w] && tg[w] == tag_in) begin
        hfound = 1'b1;
        hway   = RW'(w);
      end
    end
    cnt = '0;
    for (int w = 0; w < WAYS; w++) cnt = cnt + CW'(vrow[w]);
    vfound = 1'b0;
    vway   = '0;
    best   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (vrow[w] && (!vfound || rk[w] >= best)) begin
        best   = rk[w];
        vway   = RW'(w);
        vfound = 1'b1;
      end
    end
    hit       = hfound && (kind_q <= 3'(sacl_pkg::KIND_INVAL));
    is_wr     = kind_q == 3'(sacl_pkg::KIND_WRITE);
    is_demand = kind_q == 3'(sacl_pkg::KIND_READ) || is_wr;
    do_ins    = 1'b0;
    ins_dt    = 1'b0;
    ins_pf    = 1'b0;
    do_rem    = 1'b0;
    rway      = hway;
    fv        = 1'b0;
    pu        = 1'b0;
    if (is_demand) begin
      if (hit) begin
        if (!(wt && is_wr)) begin
          pu = pf[hway];
          npf[hway] = 1'b0;
          if (is_wr) ndt[hway] = 1'b1;
        end
        r = rk[hway];
        for (int w = 0; w < WAYS; w++) begin
          if (vrow[w] && rk[w] < r) nrk[w] = rk[w] + 1'b1;
        end
        nrk[hway] = '0;
      end else if (!(wt && is_wr)) begin
        fv     = 1'b1;
        do_ins = 1'b1;
        ins_dt = is_wr && !wt;
      end
    end else if (kind_q == 3'(sacl_pkg::KIND_PREFETCH)) begin
      if (!hit) begin
        do_ins = 1'b1;
        ins_pf = 1'b1;
      end
    end else if (kind_q == 3'(sacl_pkg::KIND_INVAL)) begin
      do_rem = hit;
    end
    evict = do_ins && (cnt == CW'(WAYS)) && vfound;
    if (evict) begin
      do_rem = 1'b1;
      rway   = vway;
    end
    if (do_rem) begin
      r = nrk[rway];
      for (int w = 0; w < WAYS; w++) begin
        if (RW'(w) != rway && nv[w] && nrk[w] > r) nrk[w] = nrk[w] - 1'b1;
      end
      nv[rway]  = 1'b0;
      ndt[rway] = 1'b0;
      npf[rway] = 1'b0;
      nrk[rway] = '0;
      cnt       = cnt - 1'b1;
    end
    if (do_ins) begin
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (!nv[w]) slot = RW'(w);
      end
      if (insert_at_lru_i) begin
        nrk[slot] = cnt[RW-1:0];
      end else begin
        for (int w = 0; w < WAYS; w++) begin
          if (nv[w]) nrk[w] = nrk[w] + 1'b1;
        end
        nrk[slot] = '0;
      end
      nv[slot]  = 1'b1;
      ntg[slot] = tag_in;
      ndt[slot] = ins_dt;
      npf[slot] = ins_pf;
    end
    fl = do_ins;
    wv = evict && !wt && dt[vway];
    pw = evict && wt && pf[vway];
    wa = {tg[vway], set_idx, {OFFSET_BITS{1'b0}}};
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_wr[w*LW +: LW] = {ntg[w], ndt[w], npf[w], nrk[w]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) valid_q[s] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.execute) begin
        valid_q[set_idx] <= nv;
        out_valid_q      <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      hit_q <= hit;
      fv_q  <= fv;
      fa_q  <= fv ? {addr_q[63:OFFSET_BITS], {OFFSET_BITS{1'b0}}} : 64'd0;
      wv_q  <= wv;
      wa_q  <= wv ? wa : 64'd0;
      pu_q  <= pu;
      pw_q  <= pw;
      fl_q  <= fl;
    end
  end

  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign hit_o             = hit_q;
  assign fetch_valid_o     = fv_q;
  assign fetch_addr_o      = fa_q;
  assign writeback_valid_o = wv_q;
  assign writeback_addr_o  = wa_q;
  assign prefetch_used_o   = pu_q;
  assign prefetch_wasted_o = pw_q;
  assign filled_o          = fl_q;

endmodule

@@ hdl/set_assoc_lru_cache_tags_unit.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_unit
// Tag and state store of a set-associative cache with true LRU per set.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | kind_i, addr_i
//  out     | output    | out_valid_o/out_stall_i | hit_o .. filled_o
//  cfg     | input     | APB psel/penable      | pwdata (two 1-bit registers)
//
// For each item the set row is first read from RAM, then updated and
// written back while the result register is loaded. The next item is taken
// when the update is done. Reset clears all valid bits at once; no clearing
// pass. A stalled result holds the update until the register frees.
module set_assoc_lru_cache_tags_unit #(
  parameter int OFFSET_BITS = 6,
  parameter int INDEX_BITS  = 6,
  parameter int WAYS_LOG2   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic        fetch_valid_o,
  output logic [63:0] fetch_addr_o,
  output logic        writeback_valid_o,
  output logic [63:0] writeback_addr_o,
  output logic        prefetch_used_o,
  output logic        prefetch_wasted_o,
  output logic        filled_o
);

  sacl_pkg::ctrl_cmd_t cmd;
  sacl_pkg::ctrl_sts_t sts;
  logic                wt_q, lru_q;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q  <= 1'b0;
      lru_q <= 1'b0;
    end else if (wr_en) begin
      if ((paddr & 3'b100) == sacl_pkg::REG_WRITE_THROUGH) wt_q <= pwdata[0];
      if ((paddr & 3'b100) == sacl_pkg::REG_INSERT_AT_LRU) lru_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if ((paddr & 3'b100) == sacl_pkg::REG_WRITE_THROUGH) prdata[0] = wt_q;
    else prdata[0] = lru_q;
  end

  sacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sacl_dp #(
    .OFFSET_BITS (OFFSET_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .WAYS_LOG2   (WAYS_LOG2)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .write_through_i   (wt_q),
    .insert_at_lru_i   (lru_q),
    .kind_i            (kind_i),
    .addr_i            (addr_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .fetch_valid_o     (fetch_valid_o),
    .fetch_addr_o      (fetch_addr_o),
    .writeback_valid_o (writeback_valid_o),
    .writeback_addr_o  (writeback_addr_o),
    .prefetch_used_o   (prefetch_used_o),
    .prefetch_wasted_o (prefetch_wasted_o),
    .filled_o          (filled_o)
  );

endmodule

@@ hdl/sacl_checker.sv @@
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the cache tag unit, bound to the top level.
// ----------------------------------------------------------------------------
module sacl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic hit_o,
  input logic fetch_valid_o,
  input logic writeback_valid_o,
  input logic prefetch_wasted_o,
  input logic filled_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filled_o))
    else $error("Stalled result transfer changed.");

  a_fetch_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fetch_valid_o |-> !hit_o && filled_o)
    else $error("Fetch reported without a missing allocation.");

  a_wb_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_valid_o |-> filled_o && !hit_o)
    else $error("Writeback reported without an allocation.");

  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(writeback_valid_o && prefetch_wasted_o))
    else $error("Writeback and wasted prefetch in one result.");

endmodule

bind set_assoc_lru_cache_tags_unit sacl_checker u_sacl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .hit_o             (hit_o),
  .fetch_valid_o     (fetch_valid_o),
  .writeback_valid_o (writeback_valid_o),
  .prefetch_wasted_o (prefetch_wasted_o),
  .filled_o          (filled_o)
);
